// ===== design/profile_peak_region_finder_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the profile peak region finder
// Shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PROFILE_PEAK_REGION_FINDER_CORE_MACROS_SVH
`define PROFILE_PEAK_REGION_FINDER_CORE_MACROS_SVH

// condition must hold at every edge
`define PPR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define PPR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared constants and the result type of the profile peak region finder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppr_pkg;

    localparam int VAL_W        = 16;
    localparam int OUT_IDX_W    = 10;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 48;

    localparam int DEF_MAX_SAMPLES = 1024;
    localparam int DEF_TOP_POINTS  = 25;
    localparam int DEF_MAX_REGIONS = 5;
    localparam int DEF_HALF_WIDTH  = 2;

    // one result of a kept region
    typedef struct packed {
        logic                 last_region;
        logic [OUT_IDX_W-1:0] region_high_index;
        logic [OUT_IDX_W-1:0] region_low_index;
        logic [VAL_W-1:0]     peak_value;
        logic [OUT_IDX_W-1:0] peak_index;
    } res_t;

endpackage

`default_nettype wire

// ===== design/ppr_ram.sv =====
// ----------------------------------------------------------------------------
// ppr_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/ppr_front.sv =====
// ----------------------------------------------------------------------------
// ppr_front
// Sample intake: stores samples and keeps the sorted list of largest samples
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppr_front #(
    parameter int MAX_SAMPLES = ppr_pkg::DEF_MAX_SAMPLES,
    parameter int TOP_POINTS  = ppr_pkg::DEF_TOP_POINTS,
    localparam int IW = $clog2(MAX_SAMPLES),
    localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [ppr_pkg::VAL_W-1:0] in_value,
    input  wire logic                      in_final,
    // hand-off to the back end
    output logic                           job_start,
    input  wire logic                      job_done,
    output logic [CW-1:0]                  count,
    output logic [ppr_pkg::VAL_W-1:0]      top_val [TOP_POINTS],
    output logic [IW-1:0]                  top_idx [TOP_POINTS],
    output logic [TOP_POINTS-1:0]          top_vld,
    // profile store write port
    output logic                           ram_we,
    output logic [IW-1:0]                  ram_waddr,
    output logic [ppr_pkg::VAL_W-1:0]      ram_wdata
);

    logic [CW-1:0]               count_reg;
    logic                        pending_reg;
    logic [ppr_pkg::VAL_W-1:0]   val_reg [TOP_POINTS];
    logic [IW-1:0]               idx_reg [TOP_POINTS];
    logic [TOP_POINTS-1:0]       vld_reg;
    logic [TOP_POINTS-1:0]       gt;
    logic [TOP_POINTS-1:0]       gt_prev;
    logic [TOP_POINTS-1:0]       vld_prev;
    logic                        accept;
    logic                        take;
    logic                        insert;

    assign in_ready  = !pending_reg;
    assign accept    = in_valid && in_ready;
    assign take      = accept && (count_reg < CW'(MAX_SAMPLES));
    assign job_start = pending_reg;
    assign count     = count_reg;
    assign top_val   = val_reg;
    assign top_idx   = idx_reg;
    assign top_vld   = vld_reg;

    assign ram_we    = take;
    assign ram_waddr = count_reg[IW-1:0];
    assign ram_wdata = in_value;

    // entries that stay ahead of the new sample (ties keep the older one first)
    always_comb
    begin
        for (int p = 0; p < TOP_POINTS; p++)
        begin
            gt[p] = vld_reg[p] && (val_reg[p] >= in_value);
        end
    end

    assign gt_prev  = {gt[TOP_POINTS-2:0], 1'b1};
    assign vld_prev = {vld_reg[TOP_POINTS-2:0], 1'b1};
    assign insert   = take && !gt[TOP_POINTS-1];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pending_reg <= 1'b0;
            vld_reg     <= '0;
        end
        else if (job_done)
        begin
            count_reg   <= '0;
            pending_reg <= 1'b0;
            vld_reg     <= '0;
        end
        else
        begin
            if (take)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (accept && in_final)
            begin
                pending_reg <= 1'b1;
            end
            if (insert)
            begin
                vld_reg <= vld_reg | vld_prev;
            end
        end
    end

    // sorted insertion, one shift per entry
    for (genvar p = 0; p < TOP_POINTS; p++)
    begin : g_slot
        always_ff @(posedge clk)
        begin
            if (insert && !gt[p])
            begin
                if (gt_prev[p])
                begin
                    val_reg[p] <= in_value;
                    idx_reg[p] <= count_reg[IW-1:0];
                end
                else
                begin
                    if (p > 0)
                    begin
                        val_reg[p] <= val_reg[(p > 0) ? p - 1 : 0];
                        idx_reg[p] <= idx_reg[(p > 0) ? p - 1 : 0];
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/ppr_back.sv =====
// ----------------------------------------------------------------------------
// ppr_back
// Region forming, filtering and neighbour growth after the profile end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppr_back #(
    parameter int MAX_SAMPLES = ppr_pkg::DEF_MAX_SAMPLES,
    parameter int TOP_POINTS  = ppr_pkg::DEF_TOP_POINTS,
    parameter int MAX_REGIONS = ppr_pkg::DEF_MAX_REGIONS,
    parameter int HALF_WIDTH  = ppr_pkg::DEF_HALF_WIDTH,
    localparam int IW  = $clog2(MAX_SAMPLES),
    localparam int CW  = $clog2(MAX_SAMPLES + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      job_start,
    output logic                           job_done,
    input  wire logic [CW-1:0]             count,
    input  wire logic [ppr_pkg::VAL_W-1:0] top_val [TOP_POINTS],
    input  wire logic [IW-1:0]             top_idx [TOP_POINTS],
    input  wire logic [TOP_POINTS-1:0]     top_vld,
    // profile store read port
    output logic                           ram_re,
    output logic [IW-1:0]                  ram_raddr,
    input  wire logic [ppr_pkg::VAL_W-1:0] ram_rdata,
    // result queue
    output logic                           res_push,
    output ppr_pkg::res_t                  res_data,
    input  wire logic                      res_full
);

    localparam int TW  = $clog2(TOP_POINTS + 1);
    localparam int TIW = $clog2(TOP_POINTS);
    localparam int RW  = $clog2(MAX_REGIONS + 1);
    localparam int RIW = $clog2(MAX_REGIONS);
    localparam int DW  = $clog2(HALF_WIDTH + 1);
    localparam int VW  = ppr_pkg::VAL_W;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_FORM  = 8'b0000_0010,
        ST_KEEP  = 8'b0000_0100,
        ST_CHECK = 8'b0000_1000,
        ST_READ  = 8'b0001_0000,
        ST_EVAL  = 8'b0010_0000,
        ST_PUSH  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [TW-1:0]        i_reg;
    logic [RW-1:0]        rn_reg;
    logic [RW-1:0]        k_reg;
    logic [VW-1:0]        rv_reg [MAX_REGIONS];
    logic [IW-1:0]        ri_reg [MAX_REGIONS];
    logic [MAX_REGIONS-1:0] kept_reg;
    logic [RIW-1:0]       lastk_reg;
    logic [DW-1:0]        d_reg;
    logic                 side_reg;
    logic [IW-1:0]        nb_reg;
    logic [IW-1:0]        lo_reg;
    logic [IW-1:0]        hi_reg;

    logic                 form_end;
    logic                 near;
    logic [VW-1:0]        cur_val;
    logic [IW-1:0]        cur_idx;
    logic [VW-1:0]        pv;
    logic [IW-1:0]        pi;
    logic [MAX_REGIONS-1:0] kept_calc;
    logic [RIW-1:0]       lastk_calc;
    logic                 nb_last;
    logic                 nb_ok;
    logic [IW-1:0]        nb_addr;
    logic [CW:0]          right_sum;
    logic [VW-1:0]        diff;
    logic                 joins;

    // current top list entry and current region
    assign cur_val = top_val[i_reg[TIW-1:0]];
    assign cur_idx = top_idx[i_reg[TIW-1:0]];
    assign pv      = rv_reg[k_reg[RIW-1:0]];
    assign pi      = ri_reg[k_reg[RIW-1:0]];

    assign form_end = (i_reg == TW'(TOP_POINTS)) || (rn_reg == RW'(MAX_REGIONS))
                      || !top_vld[i_reg[TIW-1:0]];

    // distance to every region opened so far
    always_comb
    begin
        near = 1'b0;
        for (int j = 0; j < MAX_REGIONS; j++)
        begin
            if ((RW'(j) < rn_reg) &&
                (((cur_idx >= ri_reg[j]) ? (cur_idx - ri_reg[j]) : (ri_reg[j] - cur_idx))
                 <= IW'(HALF_WIDTH)))
            begin
                near = 1'b1;
            end
        end
    end

    // strength filter against the first two peaks
    always_comb
    begin
        kept_calc  = '0;
        lastk_calc = '0;
        for (int j = 0; j < MAX_REGIONS; j++)
        begin
            if ((RW'(j) < rn_reg)
                && (({4'b0, rv_reg[j]} * 20'd10) >= {4'b0, rv_reg[0]})
                && ((rn_reg <= RW'(1))
                    || (({3'b0, rv_reg[j]} * 19'd5) >= {3'b0, rv_reg[1]})))
            begin
                kept_calc[j] = 1'b1;
                lastk_calc   = RIW'(j);
            end
        end
    end

    // neighbour address and range check
    assign nb_last   = side_reg && (d_reg == DW'(HALF_WIDTH));
    assign right_sum = (CW+1)'(pi) + (CW+1)'(d_reg);
    always_comb
    begin
        if (!side_reg)
        begin
            nb_ok   = (IW'(d_reg) <= pi);
            nb_addr = pi - IW'(d_reg);
        end
        else
        begin
            nb_ok   = right_sum < (CW+1)'(count);
            nb_addr = right_sum[IW-1:0];
        end
    end

    // join test on the sample read back
    assign diff  = (pv > ram_rdata) ? (pv - ram_rdata) : (ram_rdata - pv);
    assign joins = (({3'b0, ram_rdata} * 19'd5) >= {3'b0, pv})
                   && ({2'b0, diff, 1'b0} <= ({3'b0, pv} * 19'(d_reg)));

    assign ram_re    = (state_reg == ST_READ) && nb_ok;
    assign ram_raddr = nb_addr;
    assign job_done  = (state_reg == ST_DONE);
    assign res_push  = (state_reg == ST_PUSH) && !res_full;

    assign res_data.peak_index        = ppr_pkg::OUT_IDX_W'(pi);
    assign res_data.peak_value        = pv;
    assign res_data.region_low_index  = ppr_pkg::OUT_IDX_W'(lo_reg);
    assign res_data.region_high_index = ppr_pkg::OUT_IDX_W'(hi_reg);
    assign res_data.last_region       = (k_reg[RIW-1:0] == lastk_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (job_start) state_next = ST_FORM;
            ST_FORM:  if (form_end) state_next = ST_KEEP;
            ST_KEEP:  state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (k_reg == rn_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (kept_reg[k_reg[RIW-1:0]])
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (nb_ok)
                begin
                    state_next = ST_EVAL;
                end
                else if (nb_last)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_EVAL:  state_next = nb_last ? ST_PUSH : ST_READ;
            ST_PUSH:  if (!res_full) state_next = ST_CHECK;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            rn_reg    <= '0;
            k_reg     <= '0;
            d_reg     <= '0;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg) inside
                ST_IDLE:
                begin
                    i_reg  <= '0;
                    rn_reg <= '0;
                end
                ST_FORM:
                begin
                    if (!form_end)
                    begin
                        i_reg <= i_reg + 1'b1;
                        if (!near)
                        begin
                            rn_reg <= rn_reg + 1'b1;
                        end
                    end
                end
                ST_KEEP:  k_reg <= '0;
                ST_CHECK:
                begin
                    d_reg    <= DW'(1);
                    side_reg <= 1'b0;
                    if ((k_reg != rn_reg) && !kept_reg[k_reg[RIW-1:0]])
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_READ, ST_EVAL:
                begin
                    if (state_reg == ST_EVAL || !nb_ok)
                    begin
                        side_reg <= !side_reg;
                        if (side_reg)
                        begin
                            d_reg <= d_reg + 1'b1;
                        end
                    end
                end
                ST_PUSH:  if (!res_full) k_reg <= k_reg + 1'b1;
                ST_DONE:  k_reg <= '0;
                default:  k_reg <= '0;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FORM && !form_end && !near)
        begin
            rv_reg[rn_reg[RIW-1:0]] <= cur_val;
            ri_reg[rn_reg[RIW-1:0]] <= cur_idx;
        end
        if (state_reg == ST_KEEP)
        begin
            kept_reg  <= kept_calc;
            lastk_reg <= lastk_calc;
        end
        if (state_reg == ST_CHECK)
        begin
            lo_reg <= pi;
            hi_reg <= pi;
        end
        if (state_reg == ST_READ)
        begin
            nb_reg <= nb_addr;
        end
        if (state_reg == ST_EVAL && joins)
        begin
            if (nb_reg < lo_reg)
            begin
                lo_reg <= nb_reg;
            end
            if (nb_reg > hi_reg)
            begin
                hi_reg <= nb_reg;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/ppr_queue.sv =====
// ----------------------------------------------------------------------------
// ppr_queue
// Two-entry result queue feeding the output stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "profile_peak_region_finder_core_macros.svh"

module ppr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ppr_pkg::res_t push_data,
    output logic               full,
    output logic               out_valid,
    input  wire logic          out_ready,
    output ppr_pkg::res_t      out_data
);

    ppr_pkg::res_t entry_reg [2];
    logic [1:0]    count_reg;
    logic          rd_ptr_reg;
    logic          wr_ptr_reg;
    logic          pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `PPR_ASSERT_ALWAYS(a_count_range, count_reg <= 2'd2, "queue count out of range")
    `PPR_ASSERT_IMPL(a_no_overflow, push, !full, "request pushed into full queue")
    `PPR_ASSERT_NEXT(a_drain, pop && !push && count_reg == 2'd1, !out_valid,
        "queue not empty after last request left")

endmodule

`default_nettype wire

// ===== design/profile_peak_region_finder_core.sv =====
// ----------------------------------------------------------------------------
// profile_peak_region_finder_core
// Top level: finds up to MAX_REGIONS peak regions in a streamed 1-D profile
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one 16-bit sample per request, tlast marks the final
//   sample of a profile. Samples are taken one per cycle while a profile
//   loads; the first MAX_SAMPLES are stored and ranked into the top list.
//   After the request with tlast, s_axis_tready stays low while the back end
//   runs: a start step, region opening over up to TOP_POINTS top list
//   entries, a filter step, then per region a check step and, per kept
//   region, a store read and a test per in-range neighbour (only a skip
//   when out of range) and a push step, then a last check and a done step.
//   m_axis delivers one request per kept region in opening order, tlast on
//   the last one. A two-entry queue holds results; when the receiver stalls
//   the back end waits in its push step. The next profile may start loading
//   as soon as the back end is done, while results still drain.
//   Reset clears the sample count, top list and all handshake state; the
//   profile store needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module profile_peak_region_finder_core #(
    parameter int MAX_SAMPLES = ppr_pkg::DEF_MAX_SAMPLES,
    parameter int TOP_POINTS  = ppr_pkg::DEF_TOP_POINTS,
    parameter int MAX_REGIONS = ppr_pkg::DEF_MAX_REGIONS,
    parameter int HALF_WIDTH  = ppr_pkg::DEF_HALF_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [15:0] sample_value
    input  wire logic [ppr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [9:0] peak_index, [25:10] peak_value, [35:26] region_low_index,
    // [45:36] region_high_index, [47:46] zero
    output logic [ppr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tlast
);

    localparam int IW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic                        job_start;
    logic                        job_done;
    logic [CW-1:0]               count;
    logic [ppr_pkg::VAL_W-1:0]   top_val [TOP_POINTS];
    logic [IW-1:0]               top_idx [TOP_POINTS];
    logic [TOP_POINTS-1:0]       top_vld;
    logic                        ram_we;
    logic [IW-1:0]               ram_waddr;
    logic [ppr_pkg::VAL_W-1:0]   ram_wdata;
    logic                        ram_re;
    logic [IW-1:0]               ram_raddr;
    logic [ppr_pkg::VAL_W-1:0]   ram_rdata;
    logic                        res_push;
    ppr_pkg::res_t               res_data;
    logic                        res_full;
    ppr_pkg::res_t               out_res;

    // sample intake and ranking
    ppr_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .TOP_POINTS  (TOP_POINTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_value  (s_axis_tdata[ppr_pkg::VAL_W-1:0]),
        .in_final  (s_axis_tlast),
        .job_start (job_start),
        .job_done  (job_done),
        .count     (count),
        .top_val   (top_val),
        .top_idx   (top_idx),
        .top_vld   (top_vld),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    // profile store
    ppr_ram #(
        .WIDTH (ppr_pkg::VAL_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // region forming and growth
    ppr_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .TOP_POINTS  (TOP_POINTS),
        .MAX_REGIONS (MAX_REGIONS),
        .HALF_WIDTH  (HALF_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_start (job_start),
        .job_done  (job_done),
        .count     (count),
        .top_val   (top_val),
        .top_idx   (top_idx),
        .top_vld   (top_vld),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_push  (res_push),
        .res_data  (res_data),
        .res_full  (res_full)
    );

    // result queue
    ppr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .full      (res_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    // output packing
    assign m_axis_tdata = {2'b00, out_res.region_high_index, out_res.region_low_index,
                           out_res.peak_value, out_res.peak_index};
    assign m_axis_tlast = out_res.last_region;

endmodule

`default_nettype wire

// ===== verif/profile_peak_region_finder_core_tb.sv =====
// ----------------------------------------------------------------------------
// profile_peak_region_finder_core_tb
// Streams profiles of random and directed shape into the region finder and
// checks every region request against a behavioral predictor of the block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// result checker: predicts regions from accepted samples and checks outputs
class region_scoreboard;
    localparam int MAX_SAMPLES = ppr_pkg::DEF_MAX_SAMPLES;
    localparam int TOP_POINTS  = ppr_pkg::DEF_TOP_POINTS;
    localparam int MAX_REGIONS = ppr_pkg::DEF_MAX_REGIONS;
    localparam int HALF_WIDTH  = ppr_pkg::DEF_HALF_WIDTH;

    logic [15:0]    samples[MAX_SAMPLES];
    int             n_samples;
    logic [15:0]    rank_val[TOP_POINTS];
    int             rank_idx[TOP_POINTS];
    int             n_ranked;
    ppr_pkg::res_t  pending_regions[$];
    int             mismatches;

    function void clear_profile();
        n_samples = 0;
        n_ranked  = 0;
    endfunction

    function void insert_ranked(int idx, logic [15:0] v);
        int pos;
        int i;
        pos = 0;
        while (pos < n_ranked && rank_val[pos] >= v) pos++;
        if (pos >= TOP_POINTS) return;
        i = (n_ranked < TOP_POINTS) ? n_ranked : TOP_POINTS - 1;
        while (i > pos)
        begin
            rank_val[i] = rank_val[i-1];
            rank_idx[i] = rank_idx[i-1];
            i--;
        end
        rank_val[pos] = v;
        rank_idx[pos] = idx;
        if (n_ranked < TOP_POINTS) n_ranked++;
    endfunction

    // note one accepted sample request
    function void note_sample(logic [15:0] v, logic fin);
        int             peak_idx[MAX_REGIONS];
        int             peak_val[MAX_REGIONS];
        int             n_reg;
        int             n_out;
        int             p0, p1, lo, hi, nb, a, diff;
        bit             near;
        ppr_pkg::res_t  r;
        if (n_samples < MAX_SAMPLES)
        begin
            samples[n_samples] = v;
            insert_ranked(n_samples, v);
            n_samples++;
        end
        if (!fin) return;
        // greedy region opening over the ranked list
        n_reg = 0;
        for (int i = 0; i < n_ranked && n_reg < MAX_REGIONS; i++)
        begin
            near = 0;
            for (int j = 0; j < n_reg; j++)
                if (rank_idx[i] - peak_idx[j] <= HALF_WIDTH &&
                    peak_idx[j] - rank_idx[i] <= HALF_WIDTH) near = 1;
            if (!near)
            begin
                peak_idx[n_reg] = rank_idx[i];
                peak_val[n_reg] = rank_val[i];
                n_reg++;
            end
        end
        p0 = (n_reg > 0) ? peak_val[0] : 0;
        p1 = (n_reg > 1) ? peak_val[1] : 0;
        n_out = 0;
        for (int k = 0; k < n_reg; k++)
        begin
            if (10 * peak_val[k] < p0) continue;
            if (n_reg > 1 && 5 * peak_val[k] < p1) continue;
            lo = peak_idx[k];
            hi = peak_idx[k];
            // grow over neighbours on both sides
            for (int d = 1; d <= HALF_WIDTH; d++)
                for (int s = 0; s < 2; s++)
                begin
                    nb = (s == 0) ? peak_idx[k] - d : peak_idx[k] + d;
                    if (nb < 0 || nb >= n_samples) continue;
                    a = samples[nb];
                    diff = (peak_val[k] > a) ? peak_val[k] - a : a - peak_val[k];
                    if (5 * a >= peak_val[k] && 2 * diff <= peak_val[k] * d)
                    begin
                        if (nb < lo) lo = nb;
                        if (nb > hi) hi = nb;
                    end
                end
            r.peak_index        = peak_idx[k][9:0];
            r.peak_value        = peak_val[k][15:0];
            r.region_low_index  = lo[9:0];
            r.region_high_index = hi[9:0];
            r.last_region       = 1'b0;
            pending_regions = {pending_regions, r};
            n_out++;
        end
        if (n_out > 0) pending_regions[pending_regions.size()-1].last_region = 1'b1;
        clear_profile();
    endfunction

    function void report(string what, int exp_v, int act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d actual %0d", what, exp_v, act_v);
    endfunction

    // check one accepted region request
    function void check_region(logic [47:0] data, logic last);
        ppr_pkg::res_t e;
        if (pending_regions.size() == 0)
        begin
            report("unexpected region, peak_index", -1, data[9:0]);
            return;
        end
        e = pending_regions.pop_front();
        if (data[9:0] !== e.peak_index) report("peak_index", e.peak_index, data[9:0]);
        if (data[25:10] !== e.peak_value) report("peak_value", e.peak_value, data[25:10]);
        if (data[35:26] !== e.region_low_index)
            report("region_low_index", e.region_low_index, data[35:26]);
        if (data[45:36] !== e.region_high_index)
            report("region_high_index", e.region_high_index, data[45:36]);
        if (data[47:46] !== 2'b00) report("pad bits", 0, data[47:46]);
        if (last !== e.last_region) report("last_region", e.last_region, last);
    endfunction
endclass

module profile_peak_region_finder_core_tb;
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    region_scoreboard regions_sb;
    bit               stimulus_done;
    int               burst_left;

    profile_peak_region_finder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // send one sample request, with bursts and random gaps
    task automatic send_sample(logic [15:0] v, logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        regions_sb.note_sample(v, fin);
    endtask

    task automatic idle_sender();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // profile with clustered peaks so region growth sees near values
    task automatic send_profile(int len);
        logic [15:0] v;
        int          base;
        base = $urandom_range(0, 65535);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1: v = base;
                2: v = base - $urandom_range(0, base / 3);
                default: v = base / $urandom_range(1, 8);
            endcase
            send_sample(v, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (regions_sb.pending_regions.size() != 0) @(posedge clk);
    endtask

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            case ($urandom_range(0, 3))
                0: m_axis_tready <= 1'b0;
                1: m_axis_tready <= $urandom_range(0, 1);
                default: m_axis_tready <= 1'b1;
            endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            regions_sb.check_region(m_axis_tdata, m_axis_tlast);
    end

    initial
    begin
        regions_sb = new();
        regions_sb.clear_profile();
        regions_sb.mismatches = 0;
        burst_left    = 0;
        stimulus_done = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single sample, extremes, plateau of ties, two far peaks
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b1);
        for (int i = 0; i < 6; i++) send_sample(16'h8000, i == 5);
        wait_drained();
        send_sample(16'h0100, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hF000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h0002, 1'b0);
        send_sample(16'h2000, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b1);
        idle_sender();

        // random profiles, mostly short, a few longer than the top list
        for (int p = 0; p < 8; p++)
        begin
            send_profile((p % 4 == 3) ? $urandom_range(26, 30) : $urandom_range(1, 8));
            if (p == 5) wait_drained();
        end

        s_axis_tvalid <= 1'b0;
        stimulus_done = 1;
    end

    initial
    begin
        wait (stimulus_done);
        while (regions_sb.pending_regions.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (regions_sb.mismatches == 0 && regions_sb.pending_regions.size() == 0)
            $display("profile_peak_region_finder_core regression: pass");
        else
            $display("profile_peak_region_finder_core regression: fail");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("profile_peak_region_finder_core regression: fail");
        $finish;
    end
endmodule
